/* hdl/binomial_coefficient_defines.svh */
// Assertion helpers shared by the files that check this block.
// Each macro expects clk_i and rst_ni in scope.
`ifndef BINOMIAL_COEFFICIENT_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_DEFINES_SVH

// Plain condition, checked at every edge out of reset.
`define BC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define BC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent and consequent in the same cycle.
`define BC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hdl/bc_pkg.sv */
package bc_pkg;

  localparam int unsigned N_W         = 7;   // n and k
  localparam int unsigned COEF_W      = 63;
  localparam int unsigned ACC_W       = 64;
  localparam int unsigned PROD_W      = ACC_W + N_W;
  localparam int unsigned DIV_W       = 72;  // dividend / quotient register
  localparam int unsigned CNT_W       = 7;   // counts DIV_W steps
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 64;

  typedef struct packed {
    logic load;      // take n and k, reset accumulator
    logic mul;       // acc * (n - i + 1) into the divider
    logic div_step;  // one restoring step
    logic round;     // quotient back to acc, advance i
    logic emit;      // load the output register
  } bc_cmd_t;

  typedef struct packed {
    logic special;     // result does not need the loop
    logic no_rounds;   // min(k, n-k) is zero
    logic div_last;    // final divider step this cycle
    logic last_round;  // i has reached min(k, n-k)
  } bc_sts_t;

endpackage

/* hdl/bc_ctrl.sv */
module bc_ctrl
  import bc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  output logic    s_tready_o,
  output logic    m_tvalid_o,
  input  logic    m_tready_i,
  input  bc_sts_t sts_i,
  output bc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DIV,
    S_ROUND,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;
  logic   out_free;

  assign out_free   = !valid_q || m_tready_i;
  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.special || sts_i.no_rounds) begin
          state_d = S_OUT;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = sts_i.last_round ? S_OUT : S_MUL;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_o.emit) begin
      valid_d = 1'b1;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

endmodule

/* hdl/bc_datapath.sv */
module bc_datapath
  import bc_pkg::*;
#(
  parameter int unsigned MAX_N = 66
) (
  input  logic              clk_i,
  input  logic [N_W-1:0]    n_i,
  input  logic [N_W-1:0]    k_i,
  input  bc_cmd_t           cmd_i,
  output bc_sts_t           sts_o,
  output logic [COEF_W-1:0] coef_o
);

  logic [N_W-1:0]    n_q, k_q, kmin_q, i_q;
  logic [ACC_W-1:0]  acc_q;
  logic [DIV_W-1:0]  div_q;
  logic [N_W-1:0]    rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [COEF_W-1:0] coef_q;

  logic [N_W-1:0]    n_minus_k;
  logic [N_W-1:0]    factor;
  logic [PROD_W-1:0] prod;
  logic [N_W:0]      rem_shift;
  logic              rem_ge;
  logic [COEF_W-1:0] result;

  assign n_minus_k = n_i - k_i;
  assign factor    = n_q - i_q + N_W'(1);
  assign prod      = PROD_W'(acc_q) * PROD_W'(factor);

  // Restoring division by i, one quotient bit per step.
  assign rem_shift = {rem_q, div_q[DIV_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, i_q});

  assign sts_o.special    = (k_q == '0) || (n_q == '0) || (k_q > n_q) ||
                            (n_q > N_W'(MAX_N));
  assign sts_o.no_rounds  = (kmin_q == '0);
  assign sts_o.div_last   = (cnt_q == CNT_W'(DIV_W - 1));
  assign sts_o.last_round = (i_q == kmin_q);

  always_comb begin
    if (k_q == '0) begin
      result = COEF_W'(1);
    end else if ((n_q == '0) || (k_q > n_q)) begin
      result = '0;
    end else if (n_q > N_W'(MAX_N)) begin
      result = '1;
    end else begin
      result = acc_q[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q    <= n_i;
      k_q    <= k_i;
      kmin_q <= (k_i > n_minus_k) ? n_minus_k : k_i;
      i_q    <= N_W'(1);
      acc_q  <= ACC_W'(1);
    end
    if (cmd_i.mul) begin
      div_q <= DIV_W'(prod);
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      div_q <= {div_q[DIV_W-2:0], rem_ge};
      rem_q <= rem_ge ? N_W'(rem_shift - {1'b0, i_q}) : rem_shift[N_W-1:0];
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.round) begin
      acc_q <= div_q[ACC_W-1:0];
      i_q   <= i_q + N_W'(1);
    end
    if (cmd_i.emit) begin
      coef_q <= result;
    end
  end

  assign coef_o = coef_q;

endmodule

/* hdl/binomial_coefficient.sv */
// Channel  | Dir | Handshake                      | Data
// ---------+-----+--------------------------------+---------------------------------
// s_axis   | in  | s_axis_tvalid_i/s_axis_tready_o | tdata[6:0] n, [13:7] k
// m_axis   | out | m_axis_tvalid_o/m_axis_tready_i | tdata[62:0] coefficient
//
// One item at a time. Special cases (k zero, k above n, n zero, n above
// MAX_N, k equal to n) go from the check straight to loading the output
// register. Otherwise each of the min(k, n-k) rounds is one multiply into
// the divider, 72 restoring steps and one write-back, then the output
// register is loaded. A new item is accepted only once the last has been
// loaded into the output register and the block is idle again.
// Reset clears the controller and the output valid; no clearing pass.
// Input is ready only while idle. A result waiting on m_axis does not block
// the next accept; hold only before loading a new result into a still-full
// output register.
`include "binomial_coefficient_defines.svh"

module binomial_coefficient
  import bc_pkg::*;
#(
  parameter int unsigned MAX_N = 66
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [6:0] n, [13:7] k, rest zero
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // [62:0] coefficient, [63] zero
);

  bc_cmd_t           cmd;
  bc_sts_t           sts;
  logic [COEF_W-1:0] coef;

  // Sequencer: accept, check, multiply/divide rounds, emit.
  bc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Accumulator, 64x7 multiplier, serial divider and output register.
  bc_datapath #(
    .MAX_N (MAX_N)
  ) u_datapath (
    .clk_i  (clk_i),
    .n_i    (s_axis_tdata_i[N_W-1:0]),
    .k_i    (s_axis_tdata_i[2*N_W-1:N_W]),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .coef_o (coef)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'(coef);

  // At most one datapath command per cycle.
  `BC_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
  // No second accept right after the first: one item in flight.
  `BC_ASSERT_NEXT(a_one_item, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "two accepts")
  // Never overwrite a result that has not been taken.
  `BC_ASSERT_SAME(a_no_overwrite, cmd.emit, !m_axis_tvalid_o || m_axis_tready_i, "result lost")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import bc_pkg::*;

  localparam int unsigned MAX_N       = 66;
  localparam int unsigned RAND_ITEMS  = 228;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned DRAIN_CYCLES = 64;

  typedef struct {
    logic [N_W-1:0]    n;
    logic [N_W-1:0]    k;
    logic [COEF_W-1:0] coef;
  } coef_pending_t;

  // Holds the coefficients owed by the block, oldest first.
  class coef_scoreboard;
    coef_pending_t pending_q[$];
    int unsigned   errors;

    // n choose k by the multiplicative method, exact with a 72-bit product.
    function logic [COEF_W-1:0] n_choose_k(logic [N_W-1:0] n, logic [N_W-1:0] k);
      logic [ACC_W-1:0] acc;
      logic [DIV_W-1:0] prod;
      logic [N_W-1:0]   rounds;
      if (k == 0) return COEF_W'(1);
      if (n == 0 || k > n) return '0;
      // Too large to be trusted: saturate.
      if (n > MAX_N) return '1;
      rounds = (k > n - k) ? n - k : k;
      acc = ACC_W'(1);
      for (int unsigned i = 1; i <= rounds; i++) begin
        prod = DIV_W'(acc) * DIV_W'(n - N_W'(i) + N_W'(1));
        acc  = ACC_W'(prod / DIV_W'(i));
      end
      return acc[COEF_W-1:0];
    endfunction

    function void note_item(logic [N_W-1:0] n, logic [N_W-1:0] k);
      coef_pending_t entry;
      entry.n    = n;
      entry.k    = k;
      entry.coef = n_choose_k(n, k);
      pending_q.push_back(entry);
    endfunction

    function void check_coef(logic [OUT_TDATA_W-1:0] tdata);
      coef_pending_t entry;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("coefficient %0d arrived with no item pending", tdata[COEF_W-1:0]);
        return;
      end
      entry = pending_q.pop_front();
      if (tdata[COEF_W-1:0] !== entry.coef) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("coefficient mismatch for n=%0d k=%0d: expected %0d, got %0d",
                   entry.n, entry.k, entry.coef, tdata[COEF_W-1:0]);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;    // [6:0] n, [13:7] k, rest zero
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;         // [62:0] coefficient, [63] zero

  int unsigned    tx_idle_pct = 0;
  int unsigned    rx_idle_pct = 0;
  logic           hold_req = 1'b0;
  coef_scoreboard coef_sb;

  binomial_coefficient #(
    .MAX_N(MAX_N)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  // Offer one item, idling first at random, and hold it until accepted.
  task automatic push_item(input logic [N_W-1:0] n, input logic [N_W-1:0] k);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_TDATA_W - 2 * N_W){1'b0}}, k, n};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int unsigned hold_left;
    logic        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Sample both handshakes at the edge that completes them.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        coef_sb.note_item(s_axis_tdata_i[N_W-1:0], s_axis_tdata_i[2*N_W-1:N_W]);
      if (m_axis_tvalid_o && m_axis_tready_i)
        coef_sb.check_coef(m_axis_tdata_o);
    end
  end

  initial begin
    logic [N_W-1:0] n;
    logic [N_W-1:0] k;
    int unsigned    pick;
    coef_sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 7;
    rx_idle_pct = 77;
    hold_req <= 1'b1;

    // Corners: k zero, k above n, n zero, n above the limit, k equal to n.
    push_item(7'd0, 7'd0);
    push_item(7'd0, 7'd1);
    push_item(7'd0, 7'd127);
    push_item(7'd127, 7'd0);
    push_item(7'd127, 7'd127);
    push_item(7'd127, 7'd1);
    push_item(7'd127, 7'd126);
    push_item(7'd67, 7'd1);
    push_item(7'd67, 7'd67);
    push_item(7'd100, 7'd127);
    push_item(7'd5, 7'd6);
    push_item(7'd66, 7'd67);
    push_item(7'd66, 7'd0);
    push_item(7'd66, 7'd66);
    push_item(7'd66, 7'd1);
    push_item(7'd66, 7'd65);
    push_item(7'd1, 7'd0);
    push_item(7'd1, 7'd1);
    push_item(7'd2, 7'd1);
    push_item(7'd10, 7'd3);
    push_item(7'd10, 7'd7);
    push_item(7'd64, 7'd32);
    push_item(7'd65, 7'd32);
    push_item(7'd66, 7'd33);

    // Mostly legal n with random k, some short loops, the rest raw noise.
    for (int unsigned idx = 0; idx < RAND_ITEMS; idx++) begin
      if (idx == RAND_ITEMS / 3) begin
        tx_idle_pct = 77;
        rx_idle_pct = 7;
      end else if (idx == 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 50) begin
        n = N_W'($urandom_range(MAX_N, 1));
        k = N_W'($urandom_range(n, 0));
      end else if (pick < 70) begin
        n = N_W'($urandom_range(MAX_N, 1));
        k = N_W'($urandom_range(3, 0));
        if (k > n) k = n;
        if ($urandom_range(1)) k = n - k;
      end else begin
        n = N_W'($urandom_range(127, 0));
        k = N_W'($urandom_range(127, 0));
      end
      push_item(n, k);
    end
    s_axis_tvalid_i <= 1'b0;

    // Let the monitor note the last item before draining.
    @(posedge clk_i);
    while (coef_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (coef_sb.errors == 0 && coef_sb.pending_q.size() == 0) begin
      $display("binomial_coefficient verification clean");
    end else begin
      $display("binomial_coefficient verification failed");
    end
    $finish;
  end

  // Worst case is well under ten milliseconds of simulated time.
  initial begin
    #50_000_000;
    $display("binomial_coefficient verification failed");
    $finish;
  end

endmodule
